/* rtl/smtk_pkg.sv */
// shared constants, types and exp tables of the softmax top-k expert router
`default_nettype none
package smtk_pkg;

  localparam int MAX_EXPERTS = 256;
  localparam int MAX_PICKS   = 32;

  localparam int IDX_W  = $clog2(MAX_EXPERTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int PIX_W  = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
  localparam int PCNT_W = $clog2(MAX_PICKS) + 1;

  localparam int SCORE_W = 32;
  localparam int E_W     = 17;
  localparam int SUM_W   = IDX_W + E_W;
  localparam int PSUM_W  = $clog2(MAX_PICKS) + E_W;
  localparam int WGT_W   = 20;
  localparam int ID_W    = 8;
  localparam int DIV_W   = (SUM_W > WGT_W) ? SUM_W : WGT_W;
  localparam int NUM_W   = E_W + 16;
  localparam int QUO_W   = WGT_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_EXPERTS  = 3'd0,
    REG_NUM_USED     = 3'd1,
    REG_LOGIT_SCALE  = 3'd2,
    REG_CLAMP_LOW    = 3'd3,
    REG_CLAMP_HIGH   = 3'd4,
    REG_NORMALIZE_ON = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } smtk_tag_t;

  // exp(-i), Q1.16
  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd24109;
      4'd2:  r = 17'd8869;
      4'd3:  r = 17'd3263;
      4'd4:  r = 17'd1200;
      4'd5:  r = 17'd442;
      4'd6:  r = 17'd162;
      4'd7:  r = 17'd60;
      4'd8:  r = 17'd22;
      4'd9:  r = 17'd8;
      4'd10: r = 17'd3;
      4'd11: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-j/16), Q1.16
  function automatic logic [16:0] exp_frac(input logic [3:0] j);
    logic [16:0] r;
    case (j)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/softmax_topk_expert_router.sv */
// softmax top-k expert router top level: load, softmax scans, picks, weights
// a row loads at one logit per cycle; after the last logit the row runs a max scan,
//   an exp scan, one divide per expert, k pick scans over n experts and k weights
//   (divided only with normalization on), n the expert count and k the pick count,
//   before its last result, plus any output stalls
// throughput: one row at a time; the store ram's single read port and the
//   shared serial divider set the row time, input stalls until results are issued
// reset: synchronous active-low, clears config to defaults and all control state
`default_nettype none
module softmax_topk_expert_router import smtk_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input items
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [31:0]     in_logit,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic        [ID_W-1:0]      out_expert_id,
  output logic        [WGT_W-1:0]     out_weight,
  output logic                        out_last_pick,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_LOAD, S_MAX, S_EXP, S_DRD, S_DST, S_DWAIT,
    S_PICK, S_PFIN, S_OCALC, S_OWAIT, S_OEMIT
  } state_t;

  // configuration registers
  logic [8:0]  num_experts_r;
  logic [5:0]  num_used_r;
  logic [23:0] logit_scale_r;
  logic [19:0] clamp_low_r;
  logic [19:0] clamp_high_r;
  logic        normalize_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_experts_r  <= 9'd256;
      num_used_r     <= 6'd8;
      logit_scale_r  <= 24'd65536;
      clamp_low_r    <= 20'd4;
      clamp_high_r   <= 20'hFFFFF;
      normalize_on_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_EXPERTS:  num_experts_r  <= cfg_data[8:0];
        REG_NUM_USED:     num_used_r     <= cfg_data[5:0];
        REG_LOGIT_SCALE:  logit_scale_r  <= cfg_data[23:0];
        REG_CLAMP_LOW:    clamp_low_r    <= cfg_data[19:0];
        REG_CLAMP_HIGH:   clamp_high_r   <= cfg_data[19:0];
        REG_NORMALIZE_ON: normalize_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective row length and pick count
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] n_last;
  logic [8:0]       k_tmp;
  logic [PCNT_W-1:0] k_eff;

  always_comb begin
    if (num_experts_r == 9'd0) begin
      n_eff = CNT_W'(1);
    end else if (32'(num_experts_r) > MAX_EXPERTS) begin
      n_eff = CNT_W'(MAX_EXPERTS);
    end else begin
      n_eff = CNT_W'(num_experts_r);
    end
    k_tmp = (num_used_r == 6'd0) ? 9'd1 : {3'd0, num_used_r};
    if (32'(k_tmp) > 32'(n_eff)) begin
      k_tmp = 9'(n_eff);
    end
    if (32'(k_tmp) > MAX_PICKS) begin
      k_tmp = 9'(MAX_PICKS);
    end
    k_eff = PCNT_W'(k_tmp);
  end
  assign n_last = IDX_W'(n_eff - CNT_W'(1));

  // logit scaling: q16.16 times q8.16, floor shift, saturate
  logic signed [56:0] scl_prod;
  logic signed [40:0] scl_sh;
  logic        [31:0] scl_val;

  assign scl_prod = in_logit * $signed({1'b0, logit_scale_r});
  assign scl_sh   = scl_prod[56:16];
  always_comb begin
    if (scl_sh[40:31] != {10{scl_sh[40]}}) begin
      scl_val = scl_sh[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      scl_val = scl_sh[31:0];
    end
  end

  // control state
  state_t            state_r;
  logic [CNT_W-1:0]  load_cnt_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              rd_v_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic signed [31:0] row_max_r;
  logic [SUM_W-1:0]  exp_sum_r;
  logic [PSUM_W-1:0] picked_sum_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [E_W-1:0]    best_val_r;
  logic [PCNT_W-1:0] m_r;
  logic [IDX_W-1:0]  pick_id_r [MAX_PICKS];
  logic [E_W-1:0]    pick_p_r  [MAX_PICKS];
  logic [WGT_W-1:0]  w_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [WGT_W-1:0]  out_w_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  m_idx;
  assign m_idx = m_r[PIX_W-1:0];

  // score store; the top bit of a probability word marks a taken expert
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  smtk_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_EXPERTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // exp unit fed by the exp scan
  smtk_tag_t        exp_in_tag;
  smtk_tag_t        exp_out_tag;
  logic [SCORE_W:0] exp_d;
  logic [E_W-1:0]   exp_e;

  assign exp_in_tag.vld = rd_v_r && (state_r == S_EXP);
  assign exp_in_tag.idx = rd_idx_r;
  assign exp_d = {row_max_r[31], row_max_r} - {ram_rdata[31], ram_rdata};

  smtk_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (exp_in_tag),
    .d       (exp_d),
    .out_tag (exp_out_tag),
    .e       (exp_e)
  );

  // shared divider: softmax probabilities, then normalized weights
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic              div_done;
  logic [WGT_W-1:0]  div_q;
  logic [19:0]       norm_den;

  always_comb begin
    if (PSUM_W'(clamp_low_r) > picked_sum_r) begin
      norm_den = clamp_low_r;
    end else if (picked_sum_r > PSUM_W'(clamp_high_r)) begin
      norm_den = clamp_high_r;
    end else begin
      norm_den = 20'(picked_sum_r);
    end
  end

  assign div_start = (state_r == S_DST) || (state_r == S_OCALC && normalize_on_r);
  assign div_num   = (state_r == S_DST) ? {ram_rdata[E_W-1:0], 16'd0}
                                        : {pick_p_r[m_idx], 16'd0};
  assign div_den   = (state_r == S_DST) ? DIV_W'(exp_sum_r) : DIV_W'(norm_den);

  smtk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // ram port muxing
  logic scan_st;
  logic issue;
  logic in_acc;
  logic rd_last;

  assign scan_st = (state_r == S_MAX) || (state_r == S_EXP) || (state_r == S_PICK);
  assign issue   = scan_st && (cnt_r < n_eff);
  assign in_acc  = in_valid && !in_stall;
  assign rd_last = rd_v_r && (rd_idx_r == n_last);

  logic [IDX_W-1:0] sel_idx;
  assign sel_idx = found_r ? best_idx_r : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_cnt_r[IDX_W-1:0];
    ram_wdata = scl_val;
    if (state_r == S_LOAD) begin
      ram_we = in_acc;
    end else if (state_r == S_EXP) begin
      ram_we    = exp_out_tag.vld;
      ram_waddr = exp_out_tag.idx;
      ram_wdata = 32'(exp_e);
    end else if (state_r == S_DWAIT) begin
      ram_we    = div_done;
      ram_waddr = cnt_r[IDX_W-1:0];
      ram_wdata = 32'(div_q);
    end else if (state_r == S_PFIN) begin
      // mark the pick taken; the next row's load rewrites the entry
      ram_we    = 1'b1;
      ram_waddr = sel_idx;
      ram_wdata = 32'h8000_0000 | 32'(best_val_r);
    end
    ram_raddr = cnt_r[IDX_W-1:0];
  end

  assign in_stall = (state_r != S_LOAD);

  // pick candidate check on the word read last cycle
  logic pick_better;
  assign pick_better = !ram_rdata[SCORE_W-1] &&
                       (!found_r || (ram_rdata[E_W-1:0] > best_val_r));

  // output register free or being drained this cycle
  logic out_load;
  assign out_load = (state_r == S_OEMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      load_cnt_r   <= '0;
      cnt_r        <= '0;
      rd_v_r       <= 1'b0;
      found_r      <= 1'b0;
      m_r          <= '0;
      out_valid_r  <= 1'b0;
      row_max_r    <= '0;
      exp_sum_r    <= '0;
      picked_sum_r <= '0;
    end else begin
      rd_v_r   <= issue;
      rd_idx_r <= cnt_r[IDX_W-1:0];
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            load_cnt_r <= load_cnt_r + CNT_W'(1);
            // row complete once the count reaches the expert count
            if ((load_cnt_r + CNT_W'(1)) >= n_eff) begin
              state_r <= S_MAX;
              cnt_r   <= '0;
            end
          end
        end
        S_MAX: begin
          if (rd_v_r) begin
            if (rd_idx_r == '0 || $signed(ram_rdata) > row_max_r) begin
              row_max_r <= $signed(ram_rdata);
            end
          end
          if (rd_last) begin
            state_r   <= S_EXP;
            cnt_r     <= '0;
            exp_sum_r <= '0;
          end
        end
        S_EXP: begin
          if (exp_out_tag.vld) begin
            exp_sum_r <= exp_sum_r + SUM_W'(exp_e);
            if (exp_out_tag.idx == n_last) begin
              state_r <= S_DRD;
              cnt_r   <= '0;
            end
          end
        end
        S_DRD: begin
          state_r <= S_DST;
        end
        S_DST: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (cnt_r[IDX_W-1:0] == n_last) begin
              state_r      <= S_PICK;
              cnt_r        <= '0;
              m_r          <= '0;
              found_r      <= 1'b0;
              picked_sum_r <= '0;
            end else begin
              cnt_r   <= cnt_r + CNT_W'(1);
              state_r <= S_DRD;
            end
          end
        end
        S_PICK: begin
          if (rd_v_r && pick_better) begin
            found_r    <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_val_r <= ram_rdata[E_W-1:0];
          end
          if (rd_last) begin
            state_r <= S_PFIN;
          end
        end
        S_PFIN: begin
          pick_id_r[m_idx]   <= sel_idx;
          pick_p_r[m_idx]    <= best_val_r;
          picked_sum_r       <= picked_sum_r + PSUM_W'(best_val_r);
          found_r            <= 1'b0;
          cnt_r              <= '0;
          if (m_r + PCNT_W'(1) == k_eff) begin
            m_r     <= '0;
            state_r <= S_OCALC;
          end else begin
            m_r     <= m_r + PCNT_W'(1);
            state_r <= S_PICK;
          end
        end
        S_OCALC: begin
          if (normalize_on_r) begin
            state_r <= S_OWAIT;
          end else begin
            w_r     <= WGT_W'(pick_p_r[m_idx]);
            state_r <= S_OEMIT;
          end
        end
        S_OWAIT: begin
          if (div_done) begin
            w_r     <= div_q;
            state_r <= S_OEMIT;
          end
        end
        S_OEMIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_id_r    <= ID_W'(pick_id_r[m_idx]);
            out_w_r     <= w_r;
            out_last_r  <= (m_r + PCNT_W'(1) == k_eff);
            if (m_r + PCNT_W'(1) == k_eff) begin
              load_cnt_r <= '0;
              m_r        <= '0;
              state_r    <= S_LOAD;
            end else begin
              m_r     <= m_r + PCNT_W'(1);
              state_r <= S_OCALC;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_expert_id = out_id_r;
  assign out_weight    = out_w_r;
  assign out_last_pick = out_last_r;

  // exp values never exceed one in q1.16
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_out_tag.vld |-> (exp_e <= E_W'(65536)))
    else $error("exp value out of range");

  // a finished scan always finds an expert not yet taken this row
  a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PFIN) |-> found_r)
    else $error("no free expert found");

  // the divider only reports back while a phase waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT || state_r == S_OWAIT))
    else $error("unexpected divider result");

endmodule
`default_nettype wire

/* rtl/smtk_ram.sv */
// generic single-write single-read ram with registered read data
`default_nettype none
module smtk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/smtk_div.sv */
// restoring divider, one quotient bit a cycle, saturating quotient
`default_nettype none
module smtk_div import smtk_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [WGT_W-1:0] quot
);

  logic             busy_r;
  logic             done_r;
  logic             sat_r;
  logic [4:0]       step_r;
  logic [DIV_W-1:0] divisor_r;
  logic [DIV_W-1:0] rem_r;
  logic [QUO_W-1:0] dvd_r;
  logic [QUO_W-1:0] quot_r;

  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [DIV_W:0]   rem_sub;
  logic             ovf;

  assign rem_sh  = {rem_r, dvd_r[QUO_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_r};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  // quotient would not fit, zero divisor included
  assign ovf     = DIV_W'(dividend[NUM_W-1:QUO_W]) >= divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        divisor_r <= divisor;
        rem_r     <= DIV_W'(dividend[NUM_W-1:QUO_W]);
        dvd_r     <= dividend[QUO_W-1:0];
        quot_r    <= '0;
        sat_r     <= ovf;
        step_r    <= '0;
        busy_r    <= !ovf;
        done_r    <= ovf;
      end else if (busy_r) begin
        rem_r  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        dvd_r  <= {dvd_r[QUO_W-2:0], 1'b0};
        quot_r <= {quot_r[QUO_W-2:0], ge};
        step_r <= step_r + 5'd1;
        if (step_r == 5'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (sat_r || quot_r[QUO_W-1]) ? '1 : quot_r[WGT_W-1:0];

endmodule
`default_nettype wire

/* rtl/smtk_exp.sv */
// three-stage exp(-d) unit from integer and fraction tables
`default_nettype none
module smtk_exp import smtk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smtk_tag_t         in_tag,
  input  wire logic [SCORE_W:0]  d,
  output smtk_tag_t              out_tag,
  output logic      [E_W-1:0]    e
);

  smtk_tag_t   t1_r, t2_r, t3_r;
  logic        z1_r, z2_r;
  logic [33:0] p1_r;
  logic [11:0] f1_r;
  logic [33:0] p2_r;
  logic [E_W-1:0] e_r;

  logic        zero;
  logic [33:0] r1;
  logic [E_W-1:0] e1;
  logic [33:0] r2;

  assign zero = (|d[SCORE_W:20]) || (d[19:16] >= 4'd12);
  assign r1   = p1_r + 34'd32768;
  assign e1   = r1[32:16];
  assign r2   = p2_r + 34'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= in_tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
    p1_r <= 34'(exp_int(d[19:16]) * exp_frac(d[15:12]));
    f1_r <= d[11:0];
    z1_r <= zero;
    p2_r <= 34'(e1 * (17'd65536 - {5'd0, f1_r}));
    z2_r <= z1_r;
    e_r  <= z2_r ? '0 : r2[32:16];
  end

  assign out_tag = t3_r;
  assign e       = e_r;

endmodule
`default_nettype wire
